// ----- src/sstat_pkg.sv -----
// sample statistics unit: shared types, state encoding and fixed constants
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sstat_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int VAR_W      = 19;
  localparam int COUNT_O_W  = 8;
  localparam int SAMPLE_TOP = 1000;

  localparam logic [SAMPLE_W-1:0]  SAMPLE_TOP_V = SAMPLE_W'(SAMPLE_TOP);
  localparam logic [SAMPLE_W-1:0]  MIN_RESET_V  = '1;
  localparam logic [COUNT_O_W-1:0] COUNT_SAT_V  = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sstat_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  mean;
    logic [SAMPLE_W-1:0]  minimum;
    logic [SAMPLE_W-1:0]  maximum;
    logic [VAR_W-1:0]     variance;
    logic [COUNT_O_W-1:0] sample_count;
    logic                 variance_undefined;
    logic                 overflowed;
  } sstat_out_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DIV_MEAN,
    ST_MUL_NSQ,
    ST_MUL_SS,
    ST_MUL_DEN,
    ST_DIV_VAR
  } sstat_state_t;

endpackage

// ----- src/sstat_accum.sv -----
// running count, sum, sum of squares, minimum, maximum and drop flag of one set
// depends on sstat_pkg
`timescale 1ns / 1ps

module sstat_accum
  import sstat_pkg::*;
#(
  parameter int MAX_SAMPLES = 128,
  parameter int CNT_W       = 8,
  parameter int SUM_W       = 17,
  parameter int SQ_W        = 27
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                clear,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [CNT_W-1:0]    count_r,
  output logic [SUM_W-1:0]    sum_r,
  output logic [SQ_W-1:0]     sumsq_r,
  output logic [SAMPLE_W-1:0] min_r,
  output logic [SAMPLE_W-1:0] max_r,
  output logic                dropped_r
);

  logic [SAMPLE_W-1:0]   x;
  logic [2*SAMPLE_W-1:0] sq;
  logic                  full;

  // saturate out-of-range samples
  assign x    = (sample > SAMPLE_TOP_V) ? SAMPLE_TOP_V : sample;
  assign sq   = x * x;
  assign full = (count_r == CNT_W'(MAX_SAMPLES));

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      count_r   <= '0;
      sum_r     <= '0;
      sumsq_r   <= '0;
      min_r     <= MIN_RESET_V;
      max_r     <= '0;
      dropped_r <= 1'b0;
    end else if (en) begin
      if (full) begin
        dropped_r <= 1'b1;
      end else begin
        count_r <= count_r + CNT_W'(1);
        sum_r   <= sum_r + SUM_W'(x);
        sumsq_r <= sumsq_r + SQ_W'(sq);
        if (x < min_r) begin
          min_r <= x;
        end
        if (x > max_r) begin
          max_r <= x;
        end
      end
    end
  end

endmodule

// ----- src/sstat_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on sstat_pkg
`timescale 1ns / 1ps

module sstat_mul
  import sstat_pkg::*;
#(
  parameter int A_W = 27,
  parameter int B_W = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [A_W-1:0]     mcand,
  input  logic [B_W-1:0]     mplier,
  output logic               running,
  output logic [A_W+B_W-1:0] product
);

  localparam int P_W = A_W + B_W;
  localparam int C_W = $clog2(B_W + 1);

  logic [P_W-1:0] prod_r;
  logic [A_W-1:0] mcand_r;
  logic [C_W-1:0] cnt_r;
  logic           running_r;
  logic [A_W:0]   add;
  logic [P_W-1:0] prod_nxt;

  // add the multiplicand into the upper half when the current bit is set, then shift right
  assign add      = {1'b0, prod_r[P_W-1:B_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
  assign prod_nxt = {add, prod_r[B_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      cnt_r     <= '0;
    end else if (load) begin
      running_r <= 1'b1;
      cnt_r     <= C_W'(B_W);
    end else if (running_r) begin
      cnt_r <= cnt_r - C_W'(1);
      if (cnt_r == C_W'(1)) begin
        running_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r  <= P_W'(mplier);
      mcand_r <= mcand;
    end else if (running_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign running = running_r;
  assign product = prod_r;

endmodule

// ----- src/sstat_div.sv -----
// restoring divider, one quotient bit per cycle; quotient must fit in Q_W bits
// depends on sstat_pkg
`timescale 1ns / 1ps

module sstat_div
  import sstat_pkg::*;
#(
  parameter int N_W = 35,
  parameter int D_W = 16,
  parameter int Q_W = 19
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           running,
  output logic [Q_W-1:0] quotient
);

  localparam int EXT_W = N_W + D_W + Q_W;
  localparam int C_W   = $clog2(Q_W + 1);

  logic [EXT_W-1:0] ext;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   dvs_r;
  logic [Q_W-1:0]   quo_r;
  logic [C_W-1:0]   cnt_r;
  logic             running_r;
  logic [D_W:0]     rem_sh;
  logic [D_W:0]     rem_sub;
  logic             fits;
  logic [D_W-1:0]   rem_nxt;

  // high dividend bits start the partial remainder, low bits shift in one per cycle
  assign ext     = EXT_W'(dividend);
  assign rem_sh  = {rem_r, quo_r[Q_W-1]};
  assign fits    = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign rem_nxt = fits ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      cnt_r     <= '0;
    end else if (load) begin
      running_r <= 1'b1;
      cnt_r     <= C_W'(Q_W);
    end else if (running_r) begin
      cnt_r <= cnt_r - C_W'(1);
      if (cnt_r == C_W'(1)) begin
        running_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= ext[Q_W +: D_W];
      quo_r <= ext[Q_W-1:0];
      dvs_r <= divisor;
    end else if (running_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[Q_W-2:0], fits};
    end
  end

  assign running  = running_r;
  assign quotient = quo_r;

endmodule

// ----- src/sample_statistics_unit.sv -----
// sample statistics unit top level: accumulator, serial multiplier, serial divider
// and the sequencer that turns a finished set into mean, min, max and variance
// depends on sstat_pkg, sstat_accum, sstat_mul, sstat_div
//
//   channel  | ports                       | transfer at rising edge with
//   ---------+-----------------------------+-------------------------------
//   input    | start, busy, in_data        | start high and busy low
//   result   | out_valid, out_data         | out_valid high (one cycle only)
//
// a sample that does not end its set is accepted while busy stays low
// the sample carrying last raises busy while the bit-serial multiplier and divider
// compute the result, for a time that grows with SUM_W = clog2(1000*MAX_SAMPLES+1);
// a set of one sample needs only the mean division
// the result strobe comes in the first cycle that busy is low again
// reset (rst_n low, synchronous) empties the set; the receiver cannot stall
`timescale 1ns / 1ps

module sample_statistics_unit
  import sstat_pkg::*;
#(
  parameter int MAX_SAMPLES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  sstat_in_t  in_data,
  output logic       out_valid,
  output sstat_out_t out_data
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = $clog2(SAMPLE_TOP * MAX_SAMPLES + 1);
  localparam int SQ_W  = $clog2(SAMPLE_TOP * SAMPLE_TOP * MAX_SAMPLES + 1);
  localparam int NUM_W = CNT_W + SQ_W;   // n * sum of squares
  localparam int DEN_W = 2 * CNT_W;      // n * (n - 1)
  localparam int P_W   = SQ_W + SUM_W;   // serial multiplier product

  // sequencer state
  sstat_state_t state_r, state_nxt;
  logic         started_r, started_nxt;

  // intermediate products
  logic [NUM_W-1:0]    nsq_r, nsq_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [SAMPLE_W-1:0] mean_r, mean_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  sstat_out_t out_r, out_nxt;

  // accumulator
  logic                acc_en;
  logic                finish;
  logic [CNT_W-1:0]    acc_count;
  logic [SUM_W-1:0]    acc_sum;
  logic [SQ_W-1:0]     acc_sumsq;
  logic [SAMPLE_W-1:0] acc_min;
  logic [SAMPLE_W-1:0] acc_max;
  logic                acc_dropped;

  // serial units
  logic             mul_load, mul_running;
  logic [SQ_W-1:0]  mul_a;
  logic [SUM_W-1:0] mul_b;
  logic [P_W-1:0]   mul_p;
  logic             div_load, div_running;
  logic [NUM_W-1:0] div_n;
  logic [DEN_W-1:0] div_d;
  logic [VAR_W-1:0] div_q;

  // finishing values
  logic [SAMPLE_W-1:0]  mean_fin;
  logic [VAR_W-1:0]     var_fin;
  logic                 undef_fin;
  logic [CNT_W+7:0]     cnt_ext;
  logic [COUNT_O_W-1:0] cnt_sat;

  logic in_xfer;

  assign busy    = (state_r != ST_ACCUM);
  assign in_xfer = start && !busy;
  assign acc_en  = in_xfer;

  sstat_accum #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .SQ_W        (SQ_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (acc_en),
    .clear     (finish),
    .sample    (in_data.sample),
    .count_r   (acc_count),
    .sum_r     (acc_sum),
    .sumsq_r   (acc_sumsq),
    .min_r     (acc_min),
    .max_r     (acc_max),
    .dropped_r (acc_dropped)
  );

  sstat_mul #(
    .A_W (SQ_W),
    .B_W (SUM_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (mul_load),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .running (mul_running),
    .product (mul_p)
  );

  sstat_div #(
    .N_W (NUM_W),
    .D_W (DEN_W),
    .Q_W (VAR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend (div_n),
    .divisor  (div_d),
    .running  (div_running),
    .quotient (div_q)
  );

  // operand selection for the shared serial units
  always_comb begin
    mul_a = acc_sumsq;
    mul_b = SUM_W'(acc_count);
    div_n = NUM_W'(acc_sum);
    div_d = DEN_W'(acc_count);
    unique case (state_r)
      ST_MUL_SS: begin
        mul_a = SQ_W'(acc_sum);
        mul_b = acc_sum;
      end
      ST_MUL_DEN: begin
        mul_a = SQ_W'(acc_count);
        mul_b = SUM_W'(CNT_W'(acc_count - CNT_W'(1)));
      end
      ST_DIV_VAR: begin
        div_n = num_r;
        div_d = den_r;
      end
      default: begin
      end
    endcase
  end

  // sample count saturates at the 8-bit field limit
  assign cnt_ext = (CNT_W + 8)'(acc_count);
  assign cnt_sat = (cnt_ext > (CNT_W + 8)'(COUNT_SAT_V)) ? COUNT_SAT_V : cnt_ext[COUNT_O_W-1:0];

  // each phase: load a unit, then wait for it, then capture
  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    nsq_nxt       = nsq_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    mean_nxt      = mean_r;
    mul_load      = 1'b0;
    div_load      = 1'b0;
    finish        = 1'b0;
    mean_fin      = mean_r;
    var_fin       = '0;
    undef_fin     = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    unique case (state_r)
      ST_ACCUM: begin
        if (in_xfer && in_data.last) begin
          state_nxt = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (!started_r) begin
          div_load    = 1'b1;
          started_nxt = 1'b1;
        end else if (!div_running) begin
          started_nxt = 1'b0;
          mean_nxt    = div_q[SAMPLE_W-1:0];
          if (acc_count < CNT_W'(2)) begin
            // single sample: variance undefined, reported as zero
            mean_fin  = div_q[SAMPLE_W-1:0];
            undef_fin = 1'b1;
            finish    = 1'b1;
            state_nxt = ST_ACCUM;
          end else begin
            state_nxt = ST_MUL_NSQ;
          end
        end
      end
      ST_MUL_NSQ: begin
        if (!started_r) begin
          mul_load    = 1'b1;
          started_nxt = 1'b1;
        end else if (!mul_running) begin
          started_nxt = 1'b0;
          nsq_nxt     = mul_p[NUM_W-1:0];
          state_nxt   = ST_MUL_SS;
        end
      end
      ST_MUL_SS: begin
        if (!started_r) begin
          mul_load    = 1'b1;
          started_nxt = 1'b1;
        end else if (!mul_running) begin
          started_nxt = 1'b0;
          // n*sumsq never falls below sum^2
          num_nxt     = nsq_r - mul_p[NUM_W-1:0];
          state_nxt   = ST_MUL_DEN;
        end
      end
      ST_MUL_DEN: begin
        if (!started_r) begin
          mul_load    = 1'b1;
          started_nxt = 1'b1;
        end else if (!mul_running) begin
          started_nxt = 1'b0;
          den_nxt     = mul_p[DEN_W-1:0];
          state_nxt   = ST_DIV_VAR;
        end
      end
      ST_DIV_VAR: begin
        if (!started_r) begin
          div_load    = 1'b1;
          started_nxt = 1'b1;
        end else if (!div_running) begin
          started_nxt = 1'b0;
          var_fin     = div_q;
          finish      = 1'b1;
          state_nxt   = ST_ACCUM;
        end
      end
      default: begin
        state_nxt   = ST_ACCUM;
        started_nxt = 1'b0;
      end
    endcase

    if (finish) begin
      out_valid_nxt              = 1'b1;
      out_nxt.mean               = mean_fin;
      out_nxt.minimum            = acc_min;
      out_nxt.maximum            = acc_max;
      out_nxt.variance           = var_fin;
      out_nxt.sample_count       = cnt_sat;
      out_nxt.variance_undefined = undef_fin;
      out_nxt.overflowed         = acc_dropped;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    nsq_r  <= nsq_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    mean_r <= mean_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/sstat_checker.sv -----
// port-level checks on the sample statistics unit, attached by bind
// depends on sstat_pkg and sample_statistics_unit
`timescale 1ns / 1ps

module sstat_checker
  import sstat_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input sstat_in_t  in_data,
  input logic       out_valid,
  input sstat_out_t out_data
);

  // result strobe lasts exactly one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // a result only follows a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding computation");

  // the last sample of a set starts the computation
  a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last) |=> busy)
    else $error("busy not raised after last sample");

  // other samples are taken one per cycle
  a_mid_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.last) |=> !busy)
    else $error("busy raised on a sample that does not end the set");

  // mean lies between minimum and maximum, and the set is not empty
  a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.minimum <= out_data.mean) && (out_data.mean <= out_data.maximum)
                  && (out_data.sample_count != '0))
    else $error("inconsistent result fields");

endmodule

bind sample_statistics_unit sstat_checker u_sstat_checker (.*);

// ----- sim/sample_statistics_unit_tb.sv -----
// testbench for sample_statistics_unit: directed and random sample sets, each result
// checked field by field against an in-bench model of mean, min, max and variance
// depends on sstat_pkg and sample_statistics_unit
`timescale 1ns / 1ps

module sample_statistics_unit_tb
  import sstat_pkg::*;
();

  localparam int MAX_SAMPLES  = 128;
  // width of the running sum; sets the length of the serial arithmetic
  localparam int SUM_W        = $clog2(SAMPLE_TOP * MAX_SAMPLES + 1);
  // busy time after a last sample, plus some margin
  localparam int DRAIN_CYCLES = 3 * SUM_W + 48 + 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 90;
  localparam int MAX_GAP      = 32;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  sstat_in_t  in_data = '0;
  logic       busy;
  logic       out_valid;
  sstat_out_t out_data;

  sample_statistics_unit #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model of the set being collected
  longint unsigned set_count;
  longint unsigned set_sum;
  longint unsigned set_sum_sq;
  longint unsigned set_min;
  longint unsigned set_max;
  logic            set_dropped;

  // statistics predicted for finished sets, oldest first
  sstat_out_t pending_stats[$];
  sstat_out_t oldest_stats;

  int error_count = 0;
  int idle_pct    = 0;
  int cycle_count = 0;

  function void clear_set_model();
    set_count   = 0;
    set_sum     = 0;
    set_sum_sq  = 0;
    set_min     = 1023;
    set_max     = 0;
    set_dropped = 1'b0;
  endfunction

  // fold one accepted sample into the model; on last, predict the set statistics
  function void fold_sample(sstat_in_t item);
    longint unsigned x;
    longint unsigned n;
    longint unsigned num;
    sstat_out_t      stats;
    x = item.sample;
    // out-of-range samples clip to full scale
    if (x > SAMPLE_TOP) x = SAMPLE_TOP;
    if (set_count < MAX_SAMPLES) begin
      set_count++;
      set_sum    += x;
      set_sum_sq += x * x;
      if (x < set_min) set_min = x;
      if (x > set_max) set_max = x;
    end else begin
      // set is full: sample dropped, but a last flag still closes the set
      set_dropped = 1'b1;
    end
    if (!item.last) return;
    n = set_count;
    stats.mean    = SAMPLE_W'((n != 0) ? set_sum / n : 0);
    stats.minimum = SAMPLE_W'(set_min);
    stats.maximum = SAMPLE_W'(set_max);
    if (n >= 2) begin
      num = n * set_sum_sq - set_sum * set_sum;
      stats.variance           = VAR_W'(num / (n * (n - 1)));
      stats.variance_undefined = 1'b0;
    end else begin
      // one sample: no spread to report
      stats.variance           = '0;
      stats.variance_undefined = 1'b1;
    end
    stats.sample_count = (n > 255) ? COUNT_SAT_V : COUNT_O_W'(n);
    stats.overflowed   = set_dropped;
    pending_stats.push_back(stats);
    clear_set_model();
  endfunction

  function void check_field(string field, longint unsigned exp_val, longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
      error_count++;
    end
  endfunction

  // result side: the strobe lasts one cycle and cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_stats.size() == 0) begin
        $error("result with no set pending: mean %0d count %0d",
               out_data.mean, out_data.sample_count);
        error_count++;
      end else begin
        oldest_stats = pending_stats.pop_front();
        check_field("mean", oldest_stats.mean, out_data.mean);
        check_field("minimum", oldest_stats.minimum, out_data.minimum);
        check_field("maximum", oldest_stats.maximum, out_data.maximum);
        check_field("variance", oldest_stats.variance, out_data.variance);
        check_field("sample_count", oldest_stats.sample_count, out_data.sample_count);
        check_field("variance_undefined", oldest_stats.variance_undefined,
                    out_data.variance_undefined);
        check_field("overflowed", oldest_stats.overflowed, out_data.overflowed);
      end
    end
  end

  // watchdog on the cycle count
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** sample_statistics_unit: FAILED **");
    $finish;
  end

  // one input transfer; called at a rising edge, returns at the accepting edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
    int        gap = 0;
    sstat_in_t item;
    item.sample = value;
    item.last   = is_last;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      // start low for the gap; raised again only at a later edge
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    // transfer happens at the first edge that sees busy low
    do @(posedge clk); while (busy);
    fold_sample(item);
  endtask

  // mostly in range, with full scale, zero and over-range values mixed in
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return SAMPLE_TOP_V;
      2:       return SAMPLE_W'($urandom_range(1023, SAMPLE_TOP + 1));
      default: return SAMPLE_W'($urandom_range(SAMPLE_TOP, 0));
    endcase
  endfunction

  task automatic send_random_set(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // hold the input off until every pending result has come back
  task automatic drain_results();
    start <= 1'b0;
    wait (pending_stats.size() == 0);
    @(posedge clk);
  endtask

  // single-sample sets: variance undefined, min = max = mean
  task automatic test_single_samples();
    send_sample('0, 1'b1);
    send_sample(SAMPLE_TOP_V, 1'b1);
    send_sample(10'd1023, 1'b1);
    send_sample(10'd513, 1'b1);
  endtask

  // widest spread, a flat full-scale set and an all-zero set
  task automatic test_extremes();
    send_sample('0, 1'b0);
    send_sample(SAMPLE_TOP_V, 1'b1);
    send_sample(SAMPLE_TOP_V, 1'b0);
    send_sample('0, 1'b1);
    repeat (2) send_sample(SAMPLE_TOP_V, 1'b0);
    send_sample(SAMPLE_TOP_V, 1'b1);
    send_sample('0, 1'b0);
    send_sample('0, 1'b1);
  endtask

  // over-range samples clip to full scale
  task automatic test_range_clipping();
    send_sample(10'd1023, 1'b0);
    send_sample(10'd1001, 1'b0);
    send_sample(SAMPLE_TOP_V, 1'b0);
    send_sample(10'd999, 1'b0);
    send_sample(10'd512, 1'b1);
    send_sample(10'd1001, 1'b0);
    send_sample('0, 1'b1);
  endtask

  // a set exactly at capacity, one and three past it with last on a dropped sample,
  // then a short set to show the unit starts clean
  task automatic test_set_full();
    send_random_set(MAX_SAMPLES);
    send_random_set(MAX_SAMPLES + 1);
    send_random_set(MAX_SAMPLES + 3);
    send_sample(10'd500, 1'b1);
  endtask

  // random sets, mostly short, now and then past capacity
  task automatic test_random_sets(input int items, input int pct);
    int sent = 0;
    int len;
    int pick;
    idle_pct = pct;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(8, 1);
      else if (pick < 95) len = $urandom_range(40, 9);
      else                len = $urandom_range(MAX_SAMPLES + 12, MAX_SAMPLES - 8);
      send_random_set(len);
      sent += len;
    end
  endtask

  initial begin
    clear_set_model();
    // synchronous reset, held low from the start and then released
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 28;
    test_single_samples();
    test_extremes();
    test_range_clipping();
    test_set_full();

    test_random_sets(PHASE_ITEMS, 28);
    drain_results();
    test_random_sets(PHASE_ITEMS, 82);
    drain_results();
    test_random_sets(PHASE_ITEMS, 0);

    // let the last set finish, then watch for stray strobes
    start <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** sample_statistics_unit: PASSED **");
    end else begin
      $display("** sample_statistics_unit: FAILED **");
    end
    $finish;
  end

endmodule
